### sv/sctm_pkg.sv
// Shared constants for the sample-to-chunk table mapper.
// Command codes, word width and the default table depth; no dependencies.
package sctm_pkg;

    localparam int WORD_W              = 32;
    localparam int CMD_W               = 2;
    localparam int DEFAULT_TABLE_DEPTH = 256;

    localparam logic [CMD_W-1:0] CMD_WRITE        = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHUNK_QUERY  = 2'd2;

    localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

endpackage

### sv/sample_chunk_table_mapper.sv
// Sample-to-chunk run table with sample and chunk lookups.
// Depends on sctm_pkg for command codes and word constants.
//
// One item at a time: a write or unused command goes straight from idle to the output state.
// A query steps through the runs in use in turn; every run that it visits goes through one table read,
// one pass of the shared 32x32 multiplier and one pass of the saturating adder.
// A sample query then runs the 32-step restoring divider and the final multiply-add, unless
// the found run's rate is zero; a chunk query ends with one more multiply-add for its last run.
// in_ready is low while an item is in work.
module sample_chunk_table_mapper #(
    parameter int TABLE_DEPTH = sctm_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  entry_index,
    input  logic [31:0] first_chunk,
    input  logic [31:0] samples_per_chunk,
    input  logic [31:0] sample_number,
    input  logic [31:0] chunk_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_chunk,
    output logic [31:0] result_first_sample
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_ADD  = 4'd3;
    localparam logic [3:0] S_TMUL = 4'd4;
    localparam logic [3:0] S_TADD = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;
    localparam logic [3:0] S_FMUL = 4'd9;
    localparam logic [3:0] S_FADD = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [63:0] run_mem [TABLE_DEPTH];
    logic [63:0] rd_data_reg;

    logic [3:0]       state_reg, state_next;
    logic [8:0]       entries_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [31:0]      sample_reg, sample_next;
    logic [31:0]      chunk_reg, chunk_next;
    logic [31:0]      start_reg, start_next;
    logic [31:0]      rate_reg, rate_next;
    logic [31:0]      total_reg, total_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      quo_reg, quo_next;
    logic [4:0]       div_cnt_reg, div_cnt_next;
    logic [63:0]      prod_reg, prod_next;
    logic [31:0]      res_chunk_reg, res_chunk_next;
    logic [31:0]      res_first_reg, res_first_next;

    logic [CNT_W-1:0] n_runs;
    logic             in_fire;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      ent_first;
    logic [31:0]      ent_rate;
    logic [31:0]      hi_val;
    logic [31:0]      mul_a;
    logic [31:0]      span;
    logic [32:0]      sum33;
    logic [31:0]      reach;
    logic [32:0]      trial;
    logic [32:0]      chunk33;
    logic             last_run;

    assign n_runs = (32'(entries_reg) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(entries_reg);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign wr_en     = in_fire && (cmd == sctm_pkg::CMD_WRITE)
                       && (32'(entry_index) < 32'(TABLE_DEPTH));
    assign wr_addr   = IDX_W'(32'(entry_index));

    assign ent_first = rd_data_reg[63:32];
    assign ent_rate  = rd_data_reg[31:0];
    assign last_run  = ((idx_reg + CNT_W'(1)) == n_runs);

    // shared saturating adder: total plus saturated product
    assign span  = (|prod_reg[63:32]) ? sctm_pkg::WORD_MAX : prod_reg[31:0];
    assign sum33 = {1'b0, total_reg} + {1'b0, span};
    assign reach = sum33[32] ? sctm_pkg::WORD_MAX : sum33[31:0];

    assign trial   = {rem_reg, quo_reg[31]} - {1'b0, rate_reg};
    assign chunk33 = {1'b0, start_reg} + {1'b0, quo_reg};

    // chunk query clips the run at the asked chunk
    assign hi_val = (chunk_reg < ent_first) ? chunk_reg : ent_first;

    always_comb
    begin
        case (state_reg)
            S_MUL:
            begin
                if (cmd_reg == sctm_pkg::CMD_CHUNK_QUERY)
                    mul_a = (hi_val > start_reg) ? hi_val - start_reg : '0;
                else
                    mul_a = (ent_first > start_reg) ? ent_first - start_reg : '0;
            end
            S_TMUL:  mul_a = (chunk_reg > start_reg) ? chunk_reg - start_reg : '0;
            S_FMUL:  mul_a = res_chunk_reg - start_reg;
            default: mul_a = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            run_mem[wr_addr] <= {first_chunk, samples_per_chunk};
        rd_data_reg <= run_mem[idx_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        sample_next    = sample_reg;
        chunk_next     = chunk_reg;
        start_next     = start_reg;
        rate_next      = rate_reg;
        total_next     = total_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        prod_next      = prod_reg;
        res_chunk_next = res_chunk_reg;
        res_first_next = res_first_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next       = cmd;
                    sample_next    = sample_number;
                    chunk_next     = chunk_number;
                    idx_next       = '0;
                    start_next     = 32'd1;
                    rate_next      = '0;
                    total_next     = '0;
                    res_chunk_next = '0;
                    res_first_next = '0;
                    state_next     = S_OUT;
                    if (cmd == sctm_pkg::CMD_SAMPLE_QUERY || cmd == sctm_pkg::CMD_CHUNK_QUERY)
                    begin
                        if (n_runs != '0)
                            state_next = S_RD;
                        else if (cmd == sctm_pkg::CMD_SAMPLE_QUERY)
                            res_chunk_next = 32'd1;
                    end
                end
            end
            S_RD:   state_next = S_MUL;
            S_MUL:
            begin
                prod_next  = mul_a * rate_reg;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (cmd_reg == sctm_pkg::CMD_SAMPLE_QUERY && sample_reg < reach)
                    state_next = S_FIN;
                else
                begin
                    total_next = reach;
                    start_next = ent_first;
                    rate_next  = ent_rate;
                    idx_next   = idx_reg + CNT_W'(1);
                    if (!last_run)
                        state_next = S_RD;
                    else if (cmd_reg == sctm_pkg::CMD_SAMPLE_QUERY)
                        state_next = S_FIN;
                    else
                        state_next = S_TMUL;
                end
            end
            S_TMUL:
            begin
                prod_next  = mul_a * rate_reg;
                state_next = S_TADD;
            end
            S_TADD:
            begin
                res_first_next = reach;
                state_next     = S_OUT;
            end
            S_FIN:
            begin
                if (rate_reg == '0)
                begin
                    res_chunk_next = 32'd1;
                    res_first_next = total_reg;
                    state_next     = S_OUT;
                end
                else
                begin
                    rem_next     = '0;
                    quo_next     = (sample_reg >= total_reg) ? sample_reg - total_reg : '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring step: shift in one dividend bit, keep the difference if it fits
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                res_chunk_next = chunk33[32] ? sctm_pkg::WORD_MAX : chunk33[31:0];
                state_next     = S_FMUL;
            end
            S_FMUL:
            begin
                prod_next  = mul_a * rate_reg;
                state_next = S_FADD;
            end
            S_FADD:
            begin
                res_first_next = reach;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            entries_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                entries_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        cmd_reg       <= cmd_next;
        sample_reg    <= sample_next;
        chunk_reg     <= chunk_next;
        start_reg     <= start_next;
        rate_reg      <= rate_next;
        total_reg     <= total_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_cnt_reg   <= div_cnt_next;
        prod_reg      <= prod_next;
        res_chunk_reg <= res_chunk_next;
        res_first_reg <= res_first_next;
    end

    assign result_chunk        = res_chunk_reg;
    assign result_first_sample = res_first_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block ready right after accepting an item");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rate_reg != '0)
        else $error("divider running with zero rate");

    a_out_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid && in_ready)
        else $error("result not released after transfer");

endmodule
